// File: design/brfb_pkg.sv
// Shared types and constants for the bounding radius pipeline.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps

package brfb_pkg;

    localparam logic [31:0] MAG_MASK  = 32'h7FFF_FFFF;
    localparam logic [31:0] F32_INF   = 32'h7F80_0000;
    localparam logic [31:0] F32_QUIET = 32'h0040_0000;

    // Smallest binary64 root that narrows to +inf: 2^128 - 2^103.
    localparam logic [63:0] F32_OVF_THRESH = 64'h47EF_FFFF_F000_0000;

    // Biased binary64 exponent of the smallest binary32 normal.
    localparam logic [10:0] F64_E_MIN_NORM32 = 11'd897;

    // Square root iteration: one root bit per step plus one round bit.
    localparam int SQRT_BITS  = 54;
    localparam int SQ_W       = 58;
    localparam int SQRT_STEPS = 3;

    // Positive binary64 value: significand with hidden bit at 52,
    // value = s * 2^(e - 1075); zero is e = 0, s = 0.
    typedef struct packed {
        logic [10:0] e;
        logic [52:0] s;
    } fp64_t;

    // Result fixed early (NaN, infinity, zero box) that bypasses the math.
    typedef struct packed {
        logic        hit;
        logic [31:0] bits;
    } special_t;

    // Pipeline control between stages.
    typedef struct packed {
        logic vld;
        logic en;
    } pipe_ctl_t;

endpackage

// File: design/bounding_radius_from_box.sv
// Top level of the bounding sphere radius pipeline.
// Depends on brfb_pkg, brfb_front, brfb_fadd, brfb_sqrt and brfb_pack.
//
// Usage:
//   Input channel (in_valid / in_stall) carries the six binary32 corner
//   coordinates of one box; output channel (out_valid / out_stall) carries
//   radius_bits, the binary32 radius. A transfer happens on a rising edge
//   with valid high and stall low. Every input transfer yields exactly one
//   output transfer, in order.
//   Stages run in order: lane pick and squaring, two binary64 adds, the
//   square root stages that each retire SQRT_STEPS root bits, and
//   narrowing. Throughput is one box per cycle while the output is not
//   stalled; the square root stages set the depth.
//   When the receiver stalls a waiting result, the whole pipeline holds and
//   in_stall rises in the same cycle; nothing is dropped or repeated.
//   Reset clears all valid bits; the pipeline is empty and ready afterwards.
//   NaN, infinite and all-zero boxes are resolved in the first stage and
//   ride along to the output beside the arithmetic.
`timescale 1ns / 1ps

module bounding_radius_from_box
#(
    parameter int SQRT_STEPS = brfb_pkg::SQRT_STEPS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] min_x_bits,
    input  logic [31:0] min_y_bits,
    input  logic [31:0] min_z_bits,
    input  logic [31:0] max_x_bits,
    input  logic [31:0] max_y_bits,
    input  logic [31:0] max_z_bits,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] radius_bits
);

    localparam int SIDE1_W = $bits(brfb_pkg::fp64_t) + $bits(brfb_pkg::special_t);
    localparam int SIDE2_W = $bits(brfb_pkg::special_t);

    logic en;

    brfb_pkg::pipe_ctl_t ctl_front;
    brfb_pkg::pipe_ctl_t ctl_add1;
    brfb_pkg::pipe_ctl_t ctl_add2;
    brfb_pkg::pipe_ctl_t ctl_sqrt;
    brfb_pkg::pipe_ctl_t ctl_pack;

    brfb_pkg::fp64_t    sq_x;
    brfb_pkg::fp64_t    sq_y;
    brfb_pkg::fp64_t    sq_z;
    brfb_pkg::special_t spec_f;
    logic               vld_f;

    brfb_pkg::fp64_t    zy;
    logic [SIDE1_W-1:0] side1_out;
    logic               vld_a1;
    brfb_pkg::fp64_t    xx_d;
    brfb_pkg::special_t spec_a1;

    brfb_pkg::fp64_t    total;
    logic [SIDE2_W-1:0] side2_out;
    logic               vld_a2;

    logic [53:0]        root;
    logic [9:0]         half;
    brfb_pkg::special_t spec_s;
    logic               vld_s;

    // Advance every stage unless a finished result is held by the receiver.
    assign en       = !(out_valid && out_stall);
    assign in_stall = !en;

    assign ctl_front = '{vld: in_valid, en: en};
    assign ctl_add1  = '{vld: vld_f, en: en};
    assign ctl_add2  = '{vld: vld_a1, en: en};
    assign ctl_sqrt  = '{vld: vld_a2, en: en};
    assign ctl_pack  = '{vld: vld_s, en: en};

    brfb_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl_front),
        .min_x_bits (min_x_bits),
        .min_y_bits (min_y_bits),
        .min_z_bits (min_z_bits),
        .max_x_bits (max_x_bits),
        .max_y_bits (max_y_bits),
        .max_z_bits (max_z_bits),
        .sq_x       (sq_x),
        .sq_y       (sq_y),
        .sq_z       (sq_z),
        .spec       (spec_f),
        .vld        (vld_f)
    );

    // z*z + y*y first; x*x rides alongside for the second add.
    brfb_fadd #(.SIDE_W(SIDE1_W)) u_add_zy
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_add1),
        .a        (sq_z),
        .b        (sq_y),
        .side_in  ({sq_x, spec_f}),
        .sum      (zy),
        .side_out (side1_out),
        .vld      (vld_a1)
    );

    assign xx_d    = side1_out[SIDE1_W-1:SIDE2_W];
    assign spec_a1 = side1_out[SIDE2_W-1:0];

    brfb_fadd #(.SIDE_W(SIDE2_W)) u_add_x
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_add2),
        .a        (zy),
        .b        (xx_d),
        .side_in  (spec_a1),
        .sum      (total),
        .side_out (side2_out),
        .vld      (vld_a2)
    );

    brfb_sqrt #(.STEPS(SQRT_STEPS)) u_sqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl_sqrt),
        .x        (total),
        .spec_in  (side2_out),
        .root     (root),
        .half     (half),
        .spec_out (spec_s),
        .vld      (vld_s)
    );

    brfb_pack u_pack
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl_pack),
        .root    (root),
        .half    (half),
        .spec_in (spec_s),
        .radius  (radius_bits),
        .vld     (out_valid)
    );

    // The radius is never negative.
    a_sign_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !radius_bits[31])
        else $error("negative radius");

    // Any NaN result is quiet.
    a_nan_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && radius_bits[30:23] == 8'hFF && radius_bits[22:0] != 23'd0)
        |-> radius_bits[22])
        else $error("signaling NaN on output");

    // The input side is held back only while a result waits at the output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    // A held result keeps its value through the next cycle.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(radius_bits)))
        else $error("held result changed");

endmodule

// File: design/brfb_front.sv
// Lane selection, exact squaring and binary64 normalization (3 stages).
// Depends on brfb_pkg.
`timescale 1ns / 1ps

module brfb_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  brfb_pkg::pipe_ctl_t ctl,
    input  logic [31:0]         min_x_bits,
    input  logic [31:0]         min_y_bits,
    input  logic [31:0]         min_z_bits,
    input  logic [31:0]         max_x_bits,
    input  logic [31:0]         max_y_bits,
    input  logic [31:0]         max_z_bits,
    output brfb_pkg::fp64_t     sq_x,
    output brfb_pkg::fp64_t     sq_y,
    output brfb_pkg::fp64_t     sq_z,
    output brfb_pkg::special_t  spec,
    output logic                vld
);

    logic [31:0] mn [3];
    logic [31:0] mx [3];
    logic [31:0] pick [3];

    logic [23:0] n_next [3];
    logic [8:0]  kk_next [3];
    logic        z_next [3];
    brfb_pkg::special_t spec1_next;

    logic [23:0] n_reg [3];
    logic [8:0]  kk_reg [3];
    logic        z_reg [3];
    brfb_pkg::special_t spec1_reg;
    logic        v1_reg;

    logic [47:0] p_reg [3];
    logic [8:0]  kk2_reg [3];
    logic        z2_reg [3];
    brfb_pkg::special_t spec2_reg;
    logic        v2_reg;

    brfb_pkg::fp64_t f_next [3];
    brfb_pkg::fp64_t f_reg [3];
    brfb_pkg::special_t spec3_reg;
    logic        v3_reg;

    assign mn[0] = min_x_bits;
    assign mn[1] = min_y_bits;
    assign mn[2] = min_z_bits;
    assign mx[0] = max_x_bits;
    assign mx[1] = max_y_bits;
    assign mx[2] = max_z_bits;

    // Stage 1: keep the first magnitude only when ordered-greater.
    always_comb
    begin
        logic [31:0] a;
        logic [31:0] b;
        logic [22:0] f;
        logic [4:0]  p;
        for (int l = 0; l < 3; l++)
        begin
            a = mn[l] & brfb_pkg::MAG_MASK;
            b = mx[l] & brfb_pkg::MAG_MASK;
            if (a <= brfb_pkg::F32_INF && b <= brfb_pkg::F32_INF && a > b)
                pick[l] = a;
            else
                pick[l] = b;
        end
        for (int l = 0; l < 3; l++)
        begin
            f = pick[l][22:0];
            p = 5'd0;
            for (int i = 0; i < 23; i++)
            begin
                if (f[i])
                    p = 5'(i);
            end
            z_next[l] = (pick[l] == 32'd0);
            if (pick[l][30:23] != 8'd0)
            begin
                n_next[l]  = {1'b1, f};
                kk_next[l] = 9'(pick[l][30:23]) + 9'd22;
            end
            else
            begin
                n_next[l]  = {1'b0, f} << (5'd23 - p);
                kk_next[l] = 9'(p);
            end
        end
        // NaN lanes take priority in the order z, y, x.
        if (pick[2] > brfb_pkg::F32_INF)
            spec1_next = '{hit: 1'b1, bits: pick[2] | brfb_pkg::F32_QUIET};
        else if (pick[1] > brfb_pkg::F32_INF)
            spec1_next = '{hit: 1'b1, bits: pick[1] | brfb_pkg::F32_QUIET};
        else if (pick[0] > brfb_pkg::F32_INF)
            spec1_next = '{hit: 1'b1, bits: pick[0] | brfb_pkg::F32_QUIET};
        else if (pick[0] == brfb_pkg::F32_INF || pick[1] == brfb_pkg::F32_INF
                 || pick[2] == brfb_pkg::F32_INF)
            spec1_next = '{hit: 1'b1, bits: brfb_pkg::F32_INF};
        else if (pick[0] == 32'd0 && pick[1] == 32'd0 && pick[2] == 32'd0)
            spec1_next = '{hit: 1'b1, bits: 32'd0};
        else
            spec1_next = '{hit: 1'b0, bits: 32'd0};
    end

    // Stage 3: place the 48-bit square with its leading one at bit 52.
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (z2_reg[l])
                f_next[l] = '{e: 11'd0, s: 53'd0};
            else if (p_reg[l][47])
                f_next[l] = '{e: {kk2_reg[l], 1'b0} + 11'd726, s: {p_reg[l], 5'd0}};
            else
                f_next[l] = '{e: {kk2_reg[l], 1'b0} + 11'd725,
                              s: {p_reg[l][46:0], 6'd0}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            v1_reg <= ctl.vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                n_reg[l]   <= n_next[l];
                kk_reg[l]  <= kk_next[l];
                z_reg[l]   <= z_next[l];
                p_reg[l]   <= n_reg[l] * n_reg[l];
                kk2_reg[l] <= kk_reg[l];
                z2_reg[l]  <= z_reg[l];
                f_reg[l]   <= f_next[l];
            end
            spec1_reg <= spec1_next;
            spec2_reg <= spec1_reg;
            spec3_reg <= spec2_reg;
        end
    end

    assign sq_x = f_reg[0];
    assign sq_y = f_reg[1];
    assign sq_z = f_reg[2];
    assign spec = spec3_reg;
    assign vld  = v3_reg;

endmodule

// File: design/brfb_fadd.sv
// Binary64 adder for positive operands, round to nearest even (3 stages:
// align, add and normalize, round). Depends on brfb_pkg.
`timescale 1ns / 1ps

module brfb_fadd
#(
    parameter int SIDE_W = 33
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  brfb_pkg::pipe_ctl_t ctl,
    input  brfb_pkg::fp64_t     a,
    input  brfb_pkg::fp64_t     b,
    input  logic [SIDE_W-1:0]   side_in,
    output brfb_pkg::fp64_t     sum,
    output logic [SIDE_W-1:0]   side_out,
    output logic                vld
);

    logic [10:0] ea_next;
    logic [55:0] big_next;
    logic [55:0] al_next;

    logic [10:0] ea_reg;
    logic [55:0] big_reg;
    logic [55:0] al_reg;
    logic [SIDE_W-1:0] sd1_reg;
    logic        v1_reg;

    logic [10:0] eb_next;
    logic [55:0] n_next;
    logic [10:0] eb_reg;
    logic [55:0] n_reg;
    logic [SIDE_W-1:0] sd2_reg;
    logic        v2_reg;

    brfb_pkg::fp64_t r_next;
    brfb_pkg::fp64_t r_reg;
    logic [SIDE_W-1:0] sd3_reg;
    logic        v3_reg;

    // Align: shift the smaller operand, fold lost bits into sticky.
    always_comb
    begin
        brfb_pkg::fp64_t bg;
        brfb_pkg::fp64_t sm;
        logic [10:0] d;
        logic [55:0] ext;
        logic [55:0] sh;
        logic        lost;
        if (b.e > a.e)
        begin
            bg = b;
            sm = a;
        end
        else
        begin
            bg = a;
            sm = b;
        end
        d   = bg.e - sm.e;
        ext = {sm.s, 3'd0};
        if (d >= 11'd56)
        begin
            sh   = 56'd0;
            lost = |sm.s;
        end
        else
        begin
            sh   = ext >> d[5:0];
            lost = |(ext & ~({56{1'b1}} << d[5:0]));
        end
        ea_next  = bg.e;
        big_next = {bg.s, 3'd0};
        al_next  = {sh[55:1], sh[0] | lost};
    end

    // Add and bring a carry back into 53 bits plus guard bits.
    always_comb
    begin
        logic [56:0] s57;
        s57 = {1'b0, big_reg} + {1'b0, al_reg};
        if (s57[56])
        begin
            n_next  = {s57[56:2], s57[1] | s57[0]};
            eb_next = ea_reg + 11'd1;
        end
        else
        begin
            n_next  = s57[55:0];
            eb_next = ea_reg;
        end
    end

    // Round to nearest even.
    always_comb
    begin
        logic        inc;
        logic [53:0] rr;
        inc = n_reg[2] & (n_reg[1] | n_reg[0] | n_reg[3]);
        rr  = {1'b0, n_reg[55:3]} + 54'(inc);
        if (rr[53])
            r_next = '{e: eb_reg + 11'd1, s: rr[53:1]};
        else
            r_next = '{e: eb_reg, s: rr[52:0]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            v1_reg <= ctl.vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            ea_reg  <= ea_next;
            big_reg <= big_next;
            al_reg  <= al_next;
            sd1_reg <= side_in;
            eb_reg  <= eb_next;
            n_reg   <= n_next;
            sd2_reg <= sd1_reg;
            r_reg   <= r_next;
            sd3_reg <= sd2_reg;
        end
    end

    assign sum      = r_reg;
    assign side_out = sd3_reg;
    assign vld      = v3_reg;

endmodule

// File: design/brfb_sqrt.sv
// Pipelined restoring square root of a positive binary64 significand,
// STEPS root bits per stage. Depends on brfb_pkg.
`timescale 1ns / 1ps

module brfb_sqrt
#(
    parameter int STEPS = brfb_pkg::SQRT_STEPS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  brfb_pkg::pipe_ctl_t ctl,
    input  brfb_pkg::fp64_t     x,
    input  brfb_pkg::special_t  spec_in,
    output logic [53:0]         root,
    output logic [9:0]          half,
    output brfb_pkg::special_t  spec_out,
    output logic                vld
);

    localparam int NST  = (brfb_pkg::SQRT_BITS + STEPS - 1) / STEPS;
    localparam int SQ_W = brfb_pkg::SQ_W;

    logic [SQ_W-1:0] acc_in [NST];
    logic [SQ_W-1:0] rem_in [NST];
    logic [SQ_W-1:0] acc_next [NST];
    logic [SQ_W-1:0] rem_next [NST];
    logic [SQ_W-1:0] acc_reg [NST];
    logic [SQ_W-1:0] rem_reg [NST];
    logic [9:0]      half_reg [NST];
    brfb_pkg::special_t spec_reg [NST];
    logic            vld_reg [NST];

    logic [SQ_W-1:0] rem0;
    logic [11:0]     half0;

    // Odd unbiased exponent: pre-double the significand.
    always_comb
    begin
        rem0 = SQ_W'(x.s);
        if (!x.e[0])
            rem0 = rem0 << 1;
        rem0  = rem0 << 1;
        half0 = (12'(x.e) + 12'd1) >> 1;
    end

    always_comb
    begin
        logic [SQ_W-1:0] a;
        logic [SQ_W-1:0] r;
        logic [SQ_W-1:0] t;
        logic [SQ_W-1:0] bitv;
        int j;
        acc_in[0] = '0;
        rem_in[0] = rem0;
        for (int s = 1; s < NST; s++)
        begin
            acc_in[s] = acc_reg[s-1];
            rem_in[s] = rem_reg[s-1];
        end
        for (int s = 0; s < NST; s++)
        begin
            a = acc_in[s];
            r = rem_in[s];
            for (int k = 0; k < STEPS; k++)
            begin
                j = s * STEPS + k;
                if (j < brfb_pkg::SQRT_BITS)
                begin
                    bitv = SQ_W'(1) << (brfb_pkg::SQRT_BITS - 1 - j);
                    t    = a + bitv;
                    if (t <= r)
                    begin
                        a = t + bitv;
                        r = r - t;
                    end
                    r = r << 1;
                end
            end
            acc_next[s] = a;
            rem_next[s] = r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < NST; s++)
                vld_reg[s] <= 1'b0;
        end
        else if (ctl.en)
        begin
            vld_reg[0] <= ctl.vld;
            for (int s = 1; s < NST; s++)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            half_reg[0] <= half0[9:0];
            spec_reg[0] <= spec_in;
            for (int s = 1; s < NST; s++)
            begin
                half_reg[s] <= half_reg[s-1];
                spec_reg[s] <= spec_reg[s-1];
            end
            for (int s = 0; s < NST; s++)
            begin
                acc_reg[s] <= acc_next[s];
                rem_reg[s] <= rem_next[s];
            end
        end
    end

    // The accumulator holds twice the root.
    assign root     = acc_reg[NST-1][54:1];
    assign half     = half_reg[NST-1];
    assign spec_out = spec_reg[NST-1];
    assign vld      = vld_reg[NST-1];

endmodule

// File: design/brfb_pack.sv
// Binary64 root assembly and narrowing to binary32 with overflow and
// subnormal handling (3 stages). Depends on brfb_pkg.
`timescale 1ns / 1ps

module brfb_pack
(
    input  logic                clk,
    input  logic                rst_n,
    input  brfb_pkg::pipe_ctl_t ctl,
    input  logic [53:0]         root,
    input  logic [9:0]          half,
    input  brfb_pkg::special_t  spec_in,
    output logic [31:0]         radius,
    output logic                vld
);

    logic [63:0] r64_next;
    logic [63:0] r64_reg;
    brfb_pkg::special_t sp1_reg;
    logic        v1_reg;

    logic [23:0] m_next;
    logic        g_next;
    logic        st_next;
    logic [7:0]  base_next;
    logic        ovf_next;
    logic [23:0] m_reg;
    logic        g_reg;
    logic        st_reg;
    logic [7:0]  base_reg;
    logic        ovf_reg;
    brfb_pkg::special_t sp2_reg;
    logic        v2_reg;

    logic [31:0] res_next;
    logic [31:0] res_reg;
    logic        v3_reg;

    // Round the root bit away and attach the exponent.
    always_comb
    begin
        logic [54:0] rp;
        logic [11:0] ex;
        rp       = (55'(root) + 55'd1) >> 1;
        ex       = 12'(half) + 12'd510;
        r64_next = 64'(rp) + {ex, 52'd0};
    end

    always_comb
    begin
        logic [10:0]  ed;
        logic         norm;
        logic [5:0]   sh;
        logic [105:0] w;
        ed   = r64_reg[62:52];
        norm = (ed >= brfb_pkg::F64_E_MIN_NORM32);
        if (norm)
            sh = 6'd29;
        else
            sh = 6'(11'd926 - ed);
        w         = {1'b1, r64_reg[51:0], 53'd0} >> sh;
        m_next    = w[76:53];
        g_next    = w[52];
        st_next   = |w[51:0];
        base_next = norm ? 8'(ed - brfb_pkg::F64_E_MIN_NORM32) : 8'd0;
        ovf_next  = (r64_reg >= brfb_pkg::F32_OVF_THRESH);
    end

    // Hidden bit adds into the exponent; a rounding carry moves on naturally.
    always_comb
    begin
        logic inc;
        inc = g_reg & (st_reg | m_reg[0]);
        if (sp2_reg.hit)
            res_next = sp2_reg.bits;
        else if (ovf_reg)
            res_next = brfb_pkg::F32_INF;
        else
            res_next = {base_reg, 23'd0} + {8'd0, m_reg} + 32'(inc);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            v1_reg <= ctl.vld;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            r64_reg  <= r64_next;
            sp1_reg  <= spec_in;
            m_reg    <= m_next;
            g_reg    <= g_next;
            st_reg   <= st_next;
            base_reg <= base_next;
            ovf_reg  <= ovf_next;
            sp2_reg  <= sp1_reg;
            res_reg  <= res_next;
        end
    end

    assign radius = res_reg;
    assign vld    = v3_reg;

endmodule

// File: tb/sv/bounding_radius_from_box_test.sv
// Self-checking testbench for bounding_radius_from_box: directed boxes, then random boxes.
// Depends on brfb_pkg and the design sources; results are predicted with real arithmetic.
`timescale 1ns / 1ps

module bounding_radius_from_box_test;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_BOXES = 1800;
    localparam int HOLD_CYCLES  = 300;   // long receiver hold-off, well past pipeline depth
    localparam int DRAIN_CYCLES = 60;    // wait after the last result before finishing
    localparam int QUIET_LIMIT  = 3000;  // cycles with no transfer before giving up

    // One directed box: six coordinates, plus a typed-in radius where it is obvious.
    typedef struct {
        logic [31:0] coord [6];
        bit          known;
        logic [31:0] radius;
    } box_row_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [31:0] min_x_bits;
    logic [31:0] min_y_bits;
    logic [31:0] min_z_bits;
    logic [31:0] max_x_bits;
    logic [31:0] max_y_bits;
    logic [31:0] max_z_bits;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] radius_bits;

    // Radii still owed by the block, oldest first.
    logic [31:0] pending_radii [$];

    int  mismatches   = 0;
    int  sender_idle  = 0;   // percent of cycles the sender stays idle
    int  recv_stall   = 0;   // percent of cycles the receiver stalls
    bit  hold_request = 0;   // ask the receiver for one long hold-off
    bit  stim_done    = 0;
    int  quiet_cycles = 0;

    box_row_t directed_boxes [$];

    bounding_radius_from_box DUT
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .min_x_bits  (min_x_bits),
        .min_y_bits  (min_y_bits),
        .min_z_bits  (min_z_bits),
        .max_x_bits  (max_x_bits),
        .max_y_bits  (max_y_bits),
        .max_z_bits  (max_z_bits),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .radius_bits (radius_bits)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #(CLK_HALF) clk = ~clk;

    // ------------------------------------------------------------------
    // Radius predictor
    // ------------------------------------------------------------------

    // Magnitude kept for one axis: the first corner wins only when it is
    // ordered-greater; ties and NaNs fall to the second corner.
    function automatic logic [31:0] kept_magnitude(logic [31:0] first, logic [31:0] second);
        logic [31:0] a;
        logic [31:0] b;
        a = first & brfb_pkg::MAG_MASK;
        b = second & brfb_pkg::MAG_MASK;
        if (a <= brfb_pkg::F32_INF && b <= brfb_pkg::F32_INF && a > b)
            return a;
        return b;
    endfunction

    // Widen a non-NaN binary32 magnitude to real, exactly.
    function automatic real magnitude_to_real(logic [31:0] mag);
        logic [63:0] wide;
        if (mag == brfb_pkg::F32_INF)
            return $bitstoreal(64'h7FF0_0000_0000_0000);
        if (mag[30:23] == 8'd0)
            // subnormal: mantissa times 2^-149
            return real'(mag[22:0]) * $bitstoreal(64'h36A0_0000_0000_0000);
        wide = {1'b0, 11'(mag[30:23] + 11'd896), mag[22:0], 29'd0};
        return $bitstoreal(wide);
    endfunction

    // Round a positive finite nonzero binary64 to nearest-even binary32.
    function automatic logic [31:0] narrow_to_f32(logic [63:0] d);
        int          ex;
        int          shift;
        logic [63:0] mant;
        logic [63:0] q;
        logic [63:0] rest;
        logic [63:0] half;
        logic [63:0] packed_bits;
        ex   = int'(d[62:52]) - 1023;
        mant = {11'd0, 1'b1, d[51:0]};
        shift = (ex >= -126) ? 29 : -(ex + 97);
        if (shift > 60)
            return 32'd0;
        q    = mant >> shift;
        rest = mant & ((64'd1 << shift) - 64'd1);
        half = 64'd1 << (shift - 1);
        if (rest > half || (rest == half && q[0]))
            q = q + 64'd1;
        if (ex < -126)
            return q[31:0];   // subnormal; a carry lands on the smallest normal
        // carry out of the significand bumps the exponent naturally
        packed_bits = (64'(ex + 127) << 23) + q - (64'd1 << 23);
        if (packed_bits >= 64'(brfb_pkg::F32_INF))
            return brfb_pkg::F32_INF;
        return packed_bits[31:0];
    endfunction

    function automatic logic [31:0] predict_radius(logic [31:0] c [6]);
        logic [31:0] kx;
        logic [31:0] ky;
        logic [31:0] kz;
        real         sq_x;
        real         sq_y;
        real         sq_z;
        real         sum;
        logic [63:0] sum_bits;
        kx = kept_magnitude(c[0], c[3]);
        ky = kept_magnitude(c[1], c[4]);
        kz = kept_magnitude(c[2], c[5]);
        // NaN lanes propagate in z, y, x order, quieted
        if (kz > brfb_pkg::F32_INF)
            return kz | brfb_pkg::F32_QUIET;
        if (ky > brfb_pkg::F32_INF)
            return ky | brfb_pkg::F32_QUIET;
        if (kx > brfb_pkg::F32_INF)
            return kx | brfb_pkg::F32_QUIET;
        sq_x = magnitude_to_real(kx);
        sq_y = magnitude_to_real(ky);
        sq_z = magnitude_to_real(kz);
        sq_x = sq_x * sq_x;
        sq_y = sq_y * sq_y;
        sq_z = sq_z * sq_z;
        sum = (sq_z + sq_y) + sq_x;
        sum_bits = $realtobits(sum);
        if (sum_bits == 64'd0)
            return 32'd0;
        if (sum_bits == 64'h7FF0_0000_0000_0000)
            return brfb_pkg::F32_INF;
        return narrow_to_f32($realtobits($sqrt(sum)));
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Random coordinate, biased toward ordinary values but with raw bit
    // patterns and special encodings mixed in.
    function automatic logic [31:0] random_coord();
        logic [31:0] specials [8];
        specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0000, 32'h7F80_0001, 32'h7F7F_FFFF, 32'h0000_0001};
        case ($urandom_range(9))
            0: return $urandom();
            1: return specials[$urandom_range(7)];
            2: return {1'($urandom()), 8'($urandom_range(4)), 23'($urandom())};
            default: return {1'($urandom()), 8'($urandom_range(147, 107)), 23'($urandom())};
        endcase
    endfunction

    function automatic void add_row(logic [31:0] mx, logic [31:0] my, logic [31:0] mz,
                                    logic [31:0] xx, logic [31:0] xy, logic [31:0] xz,
                                    bit known, logic [31:0] radius);
        box_row_t row;
        row.coord  = '{mx, my, mz, xx, xy, xz};
        row.known  = known;
        row.radius = radius;
        directed_boxes.push_back(row);
    endfunction

    // Offer one box, honoring the sender idle rate; return after its transfer.
    task automatic send_box(logic [31:0] c [6], logic [31:0] radius);
        bit go;
        while ($urandom_range(99) < sender_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        min_x_bits <= c[0];
        min_y_bits <= c[1];
        min_z_bits <= c[2];
        max_x_bits <= c[3];
        max_y_bits <= c[4];
        max_z_bits <= c[5];
        // sample stall mid-cycle, where it is settled, then take the edge
        do
        begin
            @(negedge clk);
            go = !in_stall;
            @(posedge clk);
        end
        while (!go);
        pending_radii.push_back(radius);
    endtask

    task automatic send_random(int count);
        logic [31:0] c [6];
        for (int n = 0; n < count; n++)
        begin
            for (int k = 0; k < 6; k++)
                c[k] = random_coord();
            // equal magnitudes on some axes, possibly of opposite sign
            for (int k = 0; k < 3; k++)
                if ($urandom_range(7) == 0)
                    c[k] = c[k + 3] ^ {1'($urandom()), 31'd0};
            send_box(c, predict_radius(c));
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        min_x_bits <= '0;
        min_y_bits <= '0;
        min_z_bits <= '0;
        max_x_bits <= '0;
        max_y_bits <= '0;
        max_z_bits <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero box, and +0 against -0
        add_row('0, '0, '0, '0, '0, '0, 1, 32'h0000_0000);
        add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '0, '0, '0, 1, 32'h0000_0000);
        // 3-4-5 box, picking min on x and max on y
        add_row(32'h4040_0000, '0, '0, '0, 32'h4080_0000, '0, 1, 32'h40A0_0000);
        // NaN in second corner z propagates quieted
        add_row('0, '0, '0, '0, '0, 32'h7F80_0001, 1, 32'h7FC0_0001);
        // negative signaling NaN on y: sign dropped, quiet bit set
        add_row('0, '0, '0, '0, 32'hFFA0_0000, '0, 1, 32'h7FE0_0000);
        // z NaN wins over x NaN
        add_row('0, '0, '0, 32'h7FC0_0123, '0, 32'h7F80_0042, 1, 32'h7FC0_0042);
        // NaN only in first corner is never kept
        add_row(32'h7FC0_0000, 32'hFFFF_FFFF, '0, '0, '0, '0, 1, 32'h0000_0000);
        // infinity in the first corner beats a finite second corner
        add_row(32'hFF80_0000, '0, '0, '0, '0, '0, 1, brfb_pkg::F32_INF);
        // NaN outranks infinity
        add_row(32'h7F80_0000, '0, '0, '0, 32'h7FFF_FFFF, '0, 1, 32'h7FFF_FFFF);
        // largest finite on every axis overflows on narrowing
        add_row(32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h7F7F_FFFF, '0, '0, '0, 1,
                brfb_pkg::F32_INF);
        // largest finite on one axis stays finite
        add_row('0, '0, '0, 32'h7F7F_FFFF, '0, '0, 1, 32'h7F7F_FFFF);
        // smallest subnormals, all-ones patterns, equal magnitudes, unit box
        add_row(32'h0000_0001, 32'h8000_0001, 32'h0000_0001, '0, '0, '0, 0, '0);
        add_row(32'h007F_FFFF, 32'h0080_0000, 32'h0000_0003, '0, '0, '0, 0, '0);
        add_row(32'h3F80_0000, 32'hBF80_0000, 32'h3F80_0000,
                32'hBF80_0000, 32'h3F80_0000, 32'hBF80_0000, 0, '0);
        add_row(32'h4049_0FDB, 32'hC2F6_E979, 32'h3DCC_CCCD,
                32'h4049_0FDA, 32'h42F6_E979, 32'hBDCC_CCCE, 0, '0);
        add_row(32'h5F00_0000, 32'h1F80_0000, 32'h0000_0000, '0, '0, '0, 0, '0);
        add_row(32'h7F7F_FFFF, 32'h0000_0000, 32'h0000_0000,
                32'h7F7F_FFFE, 32'h8000_0000, 32'h0000_0000, 0, '0);

        foreach (directed_boxes[i])
            send_box(directed_boxes[i].coord,
                     directed_boxes[i].known ? directed_boxes[i].radius
                                             : predict_radius(directed_boxes[i].coord));

        // random part, one idling phase after another
        send_random(RANDOM_BOXES / 4);
        sender_idle = 47;
        send_random(RANDOM_BOXES / 4);
        sender_idle  = 0;
        recv_stall   = 47;
        hold_request = 1;   // back the pipeline up while the sender keeps offering
        send_random(RANDOM_BOXES / 4);
        sender_idle = 18;
        recv_stall  = 18;
        send_random(RANDOM_BOXES / 4);
        in_valid  <= 1'b0;
        stim_done = 1;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus one long hold-off on request
    // ------------------------------------------------------------------

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(99) < recv_stall);
        end
    end

    // ------------------------------------------------------------------
    // Result checking, sampled mid-cycle where outputs are settled
    // ------------------------------------------------------------------

    always @(negedge clk)
    begin
        logic [31:0] want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_radii.size() == 0)
            begin
                $error("radius_bits: unexpected result %h", radius_bits);
                mismatches++;
            end
            else
            begin
                want = pending_radii.pop_front();
                if (radius_bits !== want)
                begin
                    $error("radius_bits: expected %h, got %h", want, radius_bits);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on either channel.
    always @(negedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // End of run
    // ------------------------------------------------------------------

    initial
    begin
        wait (stim_done && pending_radii.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_radii.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $error("timeout with %0d results outstanding", pending_radii.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
